### src/shm_pkg.sv
// Package for the sponge hash block: round constants, state types and round helper functions.
// Used by all modules in src; no dependencies.
package shm_pkg;

  localparam int unsigned LANE_W   = 64;
  localparam int unsigned NUM_RND  = 15;
  localparam int unsigned RND_W    = 4;
  localparam int unsigned NUM_RC   = 20;

  typedef logic [LANE_W-1:0] lane_t;
  typedef lane_t [3:0]       group_t;
  typedef group_t [5:0]      state_t;
  typedef lane_t [7:0]       block_t;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_PERM,
    ST_PAD,
    ST_EMIT
  } fsm_t;

  typedef struct packed {
    logic           start;
    logic [RND_W-1:0] rnd;
  } perm_ctl_t;

  function automatic lane_t rc_lookup(input logic [4:0] idx);
    lane_t v;
    unique case (idx)
      5'd0:    v = 64'h409AC7567F4A7C15;
      5'd1:    v = 64'hE2C34D9DFE94F82B;
      5'd2:    v = 64'h040BD3C37DDF743D;
      5'd3:    v = 64'hA670580AFD29F057;
      5'd4:    v = 64'hC9B8DE707C746C6D;
      5'd5:    v = 64'h6BE164B7FBBEE87B;
      5'd6:    v = 64'h8D29EAFD7B096495;
      5'd7:    v = 64'h2F167324FA53E0AF;
      5'd8:    v = 64'h515EF96A799E5CB5;
      5'd9:    v = 64'hF0877FD1F8E8D8DB;
      5'd10:   v = 64'h12CF8417783354ED;
      5'd11:   v = 64'hB4340A5EF77DD0F7;
      5'd12:   v = 64'hD67C908476C84D1D;
      5'd13:   v = 64'h79A516CBF612C92B;
      5'd14:   v = 64'h9BED9F31755D4535;
      5'd15:   v = 64'h3DDA2578F4A7C15F;
      5'd16:   v = 64'h5F02ABBE73F23D75;
      5'd17:   v = 64'hC14B31E5F33CB96B;
      5'd18:   v = 64'h60B3B62B7287359D;
      5'd19:   v = 64'h82F83C92F1D1B1B7;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic lane_t rotl(input lane_t x, input int unsigned k);
    return (x << k) | (x >> (LANE_W - k));
  endfunction

  function automatic group_t half_rot(input group_t s);
    group_t d;
    d[0] = {s[1][31:0], s[0][63:32]};
    d[1] = {s[0][31:0], s[1][63:32]};
    d[2] = {s[3][31:0], s[2][63:32]};
    d[3] = {s[2][31:0], s[3][63:32]};
    return d;
  endfunction

endpackage

### src/shm_round.sv
// One permutation round: linear layer, round constant, chi and group rotation.
// Depends on shm_pkg.
module shm_round import shm_pkg::*; (
  input  state_t           st_i,
  input  logic [RND_W-1:0] rnd_i,
  output state_t           st_o
);

  group_t a0, a1, b0, b1, c0, c1, tmp, t, a, b, c;
  state_t s;
  lane_t  rc;
  logic   odd;
  logic   rev;

  always_comb begin
    a0 = st_i[0]; a1 = st_i[1]; b0 = st_i[2];
    b1 = st_i[3]; c0 = st_i[4]; c1 = st_i[5];
    tmp = half_rot(c1);
    for (int i = 0; i < 4; i++) b1[i] = b1[i] ^ tmp[i];
    for (int i = 0; i < 4; i++) b0[i] = b0[i] ^ a1[i];
    for (int i = 0; i < 4; i++) c0[i] = c0[i] ^ rotl(a0[i], 29);
    for (int i = 0; i < 4; i++) b1[i] = b1[i] ^ rotl(a1[i], 31);
    for (int i = 0; i < 4; i++) c1[i] = c1[i] ^ rotl(a0[i], 13);
    for (int i = 0; i < 4; i++) c0[i] = c0[i] ^ b1[i];
    a0 = {a0[2], a0[1], a0[0], a0[3]};
    t  = {c0[2], c0[3], c0[0], c0[1]};
    tmp = half_rot(b1);
    for (int i = 0; i < 4; i++) c1[i] = c1[i] ^ tmp[i];
    a1 = {a1[1], a1[0], a1[3], a1[2]};
    for (int i = 0; i < 4; i++) a0[i] = a0[i] ^ t[i];
    tmp = half_rot(b0);
    for (int i = 0; i < 4; i++) a1[i] = a1[i] ^ tmp[i];
    for (int i = 0; i < 4; i++) b1[i] = b1[i] ^ (a0[i] << 7);
    for (int i = 0; i < 4; i++) c1[i] = c1[i] ^ (a1[i] >> 5);
    rc = rc_lookup({1'b0, rnd_i});
    for (int i = 0; i < 4; i++) a0[i] = a0[i] ^ rc;
    s = {c1, c0, b1, b0, a1, a0};
    odd = rnd_i[0];
    for (int p = 0; p < 2; p++) begin
      int ga, gb, gc;
      ga = p;
      gb = odd ? (p == 0 ? 3 : 2) : (p == 0 ? 2 : 3);
      gc = odd ? (p == 0 ? 5 : 4) : (p == 0 ? 4 : 5);
      a = s[ga]; b = s[gb]; c = s[gc];
      for (int i = 0; i < 4; i++) begin
        s[ga][i] = a[i] ^ (~b[i] & c[i]);
        s[gb][i] = b[i] ^ (~c[i] & a[i]);
        s[gc][i] = c[i] ^ (~a[i] & b[i]);
      end
    end
    rev = (rnd_i >= RND_W'(3) && rnd_i < RND_W'(6)) ||
          (rnd_i >= RND_W'(9) && rnd_i < RND_W'(12));
    for (int g = 0; g < 6; g++) begin
      if (rev) st_o[g] = s[(g + 1) % 6];
      else     st_o[g] = s[(g + 5) % 6];
    end
  end

endmodule

### src/shm_perm.sv
// Permutation state register with a shared round unit, one round per cycle.
// Depends on shm_pkg and shm_round.
module shm_perm import shm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  perm_ctl_t ctl_i,
  input  logic      clear_i,
  input  block_t    blk_i,
  output state_t    st_o
);

  state_t st_r, st_nxt, rnd_in, rnd_out;

  always_comb begin
    rnd_in = st_r;
    if (ctl_i.start) begin
      for (int i = 0; i < 4; i++) begin
        rnd_in[0][i] = st_r[0][i] ^ blk_i[i];
        rnd_in[1][i] = st_r[1][i] ^ blk_i[4+i];
      end
    end
  end

  shm_round u_round (.st_i(rnd_in), .rnd_i(ctl_i.rnd), .st_o(rnd_out));

  always_comb begin
    st_nxt = st_r;
    if (clear_i) st_nxt = '0;
    else if (ctl_i.start || ctl_i.rnd != '0) st_nxt = rnd_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= '0;
    else        st_r <= st_nxt;
  end

  assign st_o = st_r;

endmodule

### src/sponge_hash_512_m39_permutation_top.sv
// Top level of the 512-bit-rate sponge hash: block assembly, padding sequencer, digest output.
// Depends on shm_pkg and shm_perm.
//
// Usage:
//   Input channel in_*: one 64-bit message word per transfer. in_tdata holds msg_word and
//   valid_bits, in_tlast marks the final word. Bits past valid_bits in the last word drop.
//   Output channel out_*: eight digest lanes, A0 lanes first, then A1; out_tlast on lane 7.
//   Timing: non-final words are accepted one per cycle while in_tready is high. The
//   eighth word of a block starts the permutation, which runs through the single round
//   unit. The final word triggers one or two permutations for padding (the second one
//   after a pad state), then the eight lanes go out, one per cycle when out_tready is
//   high.
//   in_tready is low while a permutation runs or the digest is pending.
//   A stall on out_tready holds the current lane; nothing is lost.
//   Reset (rst_n low, synchronous) clears the state, block buffer and sequencer.
//   After the digest the block returns to its reset state for the next message.
module sponge_hash_512_m39_permutation_top import shm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [63:0] msg_word, [70:64] valid_bits, [71] zero
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] digest_index
  output logic        out_tlast
);

  fsm_t             state_r, state_nxt;
  block_t           buf_r, buf_nxt;
  logic [2:0]       idx_r, idx_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic             fin_r, fin_nxt;
  logic             xtra_r, xtra_nxt;
  logic [2:0]       lane_r, lane_nxt;
  logic             rem_full_r, rem_full_nxt;
  perm_ctl_t        ctl;
  logic             clear;
  state_t           st;
  logic             acc, last_rnd;
  logic [6:0]       vb;
  lane_t            mask, word;
  logic [9:0]       rem;
  logic [2:0]       f, r;

  assign acc      = in_tvalid && in_tready;
  assign last_rnd = rnd_r == RND_W'(NUM_RND - 1);
  assign vb       = (in_tdata[70:64] > 7'd64) ? 7'd64 : in_tdata[70:64];
  assign f        = vb[5:3];
  assign r        = vb[2:0];

  always_comb begin
    mask = '1;
    if (!vb[6]) begin
      for (int k = 0; k < 8; k++) begin
        if (k < f) mask[8*k +: 8] = 8'hFF;
        else if (k == f) mask[8*k +: 8] = 8'(8'hFF << (4'd8 - {1'b0, r}));
        else mask[8*k +: 8] = 8'h00;
      end
    end
    word = in_tdata[63:0] & mask;
    rem  = {idx_r, 6'd0} + {3'd0, vb};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: if (acc && (in_tlast || idx_r == 3'd7)) state_nxt = ST_PERM;
      ST_PERM:    if (last_rnd) state_nxt = fin_r ? (xtra_r ? ST_PAD : ST_EMIT) : ST_COLLECT;
      ST_PAD:     state_nxt = ST_PERM;
      ST_EMIT:    if (out_tready && lane_r == 3'd7) state_nxt = ST_COLLECT;
      default:    state_nxt = ST_COLLECT;
    endcase
  end

  always_comb begin
    in_tready = state_r == ST_COLLECT;
    out_tvalid = state_r == ST_EMIT;
    ctl.start = state_r == ST_PERM && rnd_r == '0;
    ctl.rnd   = (state_r == ST_PERM) ? rnd_r : '0;
    clear     = state_r == ST_EMIT && out_tready && lane_r == 3'd7;
  end

  // block buffer, pad sequencing, round and lane counters
  always_comb begin
    buf_nxt  = buf_r;
    idx_nxt  = idx_r;
    fin_nxt  = fin_r;
    xtra_nxt = xtra_r;
    rnd_nxt  = rnd_r;
    lane_nxt = lane_r;
    if (state_r == ST_PERM) rnd_nxt = last_rnd ? '0 : rnd_r + 1'b1;
    if (acc) begin
      if (!in_tlast) begin
        buf_nxt[idx_r] = in_tdata[63:0];
        idx_nxt = idx_r + 3'd1;
      end else begin
        buf_nxt[idx_r] = word;
        fin_nxt = 1'b1;
        if (rem[9]) begin
          // full block: absorb it, then a block with first and last bits
          xtra_nxt = 1'b1;
        end else begin
          buf_nxt[rem[8:6]][{rem[5:3], 3'd7 - rem[2:0]}] = 1'b1;
          if (rem == 10'd511) xtra_nxt = 1'b1;
          else buf_nxt[7][56] = 1'b1;
        end
      end
    end
    if (ctl.start) begin
      buf_nxt = '0;
      idx_nxt = '0;
    end
    if (state_r == ST_PERM && last_rnd && fin_r && xtra_r) begin
      buf_nxt = '0;
      buf_nxt[7][56] = 1'b1;
      if (rem_full_r) buf_nxt[0][7] = 1'b1;
      xtra_nxt = 1'b0;
    end
    if (state_r == ST_EMIT && out_tready) lane_nxt = lane_r + 3'd1;
    if (clear) begin
      fin_nxt = 1'b0;
      lane_nxt = '0;
    end
  end

  assign rem_full_nxt = (acc && in_tlast) ? rem[9] : rem_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_COLLECT;
      buf_r      <= '0;
      idx_r      <= '0;
      rnd_r      <= '0;
      fin_r      <= 1'b0;
      xtra_r     <= 1'b0;
      lane_r     <= '0;
      rem_full_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      buf_r      <= buf_nxt;
      idx_r      <= idx_nxt;
      rnd_r      <= rnd_nxt;
      fin_r      <= fin_nxt;
      xtra_r     <= xtra_nxt;
      lane_r     <= lane_nxt;
      rem_full_r <= rem_full_nxt;
    end
  end

  shm_perm u_perm (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl),
    .clear_i(clear),
    .blk_i  (buf_r),
    .st_o   (st)
  );

  assign out_tdata = st[lane_r[2]][lane_r[1:0]];
  assign out_tuser = lane_r;
  assign out_tlast = lane_r == 3'd7;

`ifndef SYNTHESIS
  a_ready_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input taken during digest");
  a_rnd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_PERM) |-> (rnd_r == '0)) else $error("round counter not idle");
  a_emit_after: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> (lane_r == '0)) else $error("digest not from lane 0");
`endif

endmodule

### tb/sv/hash_digest_checker.sv
// Digest checker for the 512-bit-rate sponge hash: watches the message and digest streams,
// computes the expected digest lanes and compares them. Depends on shm_pkg for lane types and NUM_RND.
module hash_digest_checker import shm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_lanes,
  output int          digests_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    lane_t      word;
    logic [2:0] index;
    logic       last;
  } lane_exp_t;

  localparam lane_t RCONST [20] = '{
    64'h409AC7567F4A7C15, 64'hE2C34D9DFE94F82B, 64'h040BD3C37DDF743D,
    64'hA670580AFD29F057, 64'hC9B8DE707C746C6D, 64'h6BE164B7FBBEE87B,
    64'h8D29EAFD7B096495, 64'h2F167324FA53E0AF, 64'h515EF96A799E5CB5,
    64'hF0877FD1F8E8D8DB, 64'h12CF8417783354ED, 64'hB4340A5EF77DD0F7,
    64'hD67C908476C84D1D, 64'h79A516CBF612C92B, 64'h9BED9F31755D4535,
    64'h3DDA2578F4A7C15F, 64'h5F02ABBE73F23D75, 64'hC14B31E5F33CB96B,
    64'h60B3B62B7287359D, 64'h82F83C92F1D1B1B7};

  lane_t     sponge [24];
  lane_t     pending_block [8];
  int        fill_words;
  lane_exp_t lane_queue [$];

  function automatic lane_t rol(lane_t x, int k);
    return (x << k) | (x >> (64 - k));
  endfunction

  function automatic void swap_halves(output lane_t d[4], input lane_t s[4]);
    for (int p = 0; p < 4; p += 2) begin
      d[p]   = {s[p+1][31:0], s[p][63:32]};
      d[p+1] = {s[p][31:0], s[p+1][63:32]};
    end
  endfunction

  task automatic mix_layer();
    lane_t a0[4], a1[4], b0[4], b1[4], c0[4], c1[4], t[4], h[4];
    for (int i = 0; i < 4; i++) begin
      a0[i] = sponge[i];    a1[i] = sponge[4+i];  b0[i] = sponge[8+i];
      b1[i] = sponge[12+i]; c0[i] = sponge[16+i]; c1[i] = sponge[20+i];
    end
    swap_halves(h, c1);
    for (int i = 0; i < 4; i++) begin
      b1[i] ^= h[i];
      b0[i] ^= a1[i];
      c0[i] ^= rol(a0[i], 29);
      b1[i] ^= rol(a1[i], 31);
      c1[i] ^= rol(a0[i], 13);
      c0[i] ^= b1[i];
    end
    h = '{a0[3], a0[0], a0[1], a0[2]}; a0 = h;
    t = '{c0[1], c0[0], c0[3], c0[2]};
    swap_halves(h, b1);
    for (int i = 0; i < 4; i++) c1[i] ^= h[i];
    h = '{a1[2], a1[3], a1[0], a1[1]}; a1 = h;
    for (int i = 0; i < 4; i++) a0[i] ^= t[i];
    swap_halves(h, b0);
    for (int i = 0; i < 4; i++) begin
      a1[i] ^= h[i];
      b1[i] ^= a0[i] << 7;
      c1[i] ^= a1[i] >> 5;
    end
    for (int i = 0; i < 4; i++) begin
      sponge[i] = a0[i];    sponge[4+i] = a1[i];  sponge[8+i] = b0[i];
      sponge[12+i] = b1[i]; sponge[16+i] = c0[i]; sponge[20+i] = c1[i];
    end
  endtask

  task automatic chi3(int ga, int gb, int gc);
    lane_t a, b, c;
    for (int i = 0; i < 4; i++) begin
      a = sponge[4*ga+i]; b = sponge[4*gb+i]; c = sponge[4*gc+i];
      sponge[4*ga+i] = a ^ (~b & c);
      sponge[4*gb+i] = b ^ (~c & a);
      sponge[4*gc+i] = c ^ (~a & b);
    end
  endtask

  task automatic absorb_block();
    lane_t prev [24];
    int    src;
    for (int i = 0; i < 8; i++) sponge[i] ^= pending_block[i];
    for (int r = 0; r < NUM_RND; r++) begin
      mix_layer();
      for (int i = 0; i < 4; i++) sponge[i] ^= RCONST[r % 20];
      if (r % 2 == 0) begin
        chi3(0, 2, 4); chi3(1, 3, 5);
      end else begin
        chi3(0, 3, 5); chi3(1, 2, 4);
      end
      prev = sponge;
      for (int g = 0; g < 6; g++) begin
        src = ((r / 3) % 2 == 0) ? (g + 5) % 6 : (g + 1) % 6;
        for (int i = 0; i < 4; i++) sponge[4*g+i] = prev[4*src+i];
      end
    end
    foreach (pending_block[i]) pending_block[i] = '0;
  endtask

  task automatic mark_bit(int p);
    pending_block[(p >> 6) & 7][8 * ((p >> 3) & 7) + 7 - (p & 7)] = 1'b1;
  endtask

  task automatic accept_word(lane_t word, int vbits, logic fin);
    lane_t keep;
    int    tail;
    if (!fin) begin
      pending_block[fill_words] = word;
      fill_words++;
      if (fill_words == 8) begin
        absorb_block();
        fill_words = 0;
      end
      return;
    end
    if (vbits > 64) vbits = 64;
    keep = '0;
    for (int b = 0; b < vbits; b++) keep[8 * (b / 8) + 7 - (b % 8)] = 1'b1;
    pending_block[fill_words] = word & keep;
    tail = fill_words * 64 + vbits;
    if (tail >= 512) begin
      absorb_block();
      tail = 0;
    end
    mark_bit(tail);
    if (tail == 511) absorb_block();
    mark_bit(511);
    absorb_block();
    for (int k = 0; k < 8; k++) lane_queue.push_back('{sponge[k], 3'(k), k == 7});
    foreach (sponge[i]) sponge[i] = '0;
    fill_words = 0;
  endtask

  always @(posedge clk) begin
    lane_exp_t e;
    if (!rst_n) begin
      foreach (sponge[i]) sponge[i] = '0;
      foreach (pending_block[i]) pending_block[i] = '0;
      fill_words = 0;
      lane_queue.delete();
      fail_count <= 0;
      digests_seen <= 0;
      pending_lanes <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (lane_queue.size() == 0) begin
          $display("%0t: unexpected digest lane %h idx %0d", $time, out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          e = lane_queue.pop_front();
          if (out_tdata !== e.word || out_tuser !== e.index || out_tlast !== e.last) begin
            $display("%0t: mismatch expected %h/%0d/%0b actual %h/%0d/%0b", $time,
                     e.word, e.index, e.last, out_tdata, out_tuser, out_tlast);
            fail_count <= fail_count + 1;
          end
          if (e.last) digests_seen <= digests_seen + 1;
        end
      end
      if (in_tvalid && in_tready)
        accept_word(in_tdata[63:0], int'(in_tdata[70:64]), in_tlast);
      pending_lanes <= lane_queue.size();
    end
  end
endmodule

### tb/sv/tb_top.sv
// Testbench top for the sponge hash block: drives message streams, random stalls and
// the verdict. Depends on shm_pkg, the block RTL and hash_digest_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  int          fail_count, pending_lanes, digests_seen;
  int          words_sent = 0;
  bit          calm = 1'b0;

  sponge_hash_512_m39_permutation_top u_top (.*);
  hash_digest_checker u_chk (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("sponge_hash_512_m39_permutation_top regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) out_tready <= calm || ($urandom_range(99) >= 21);
  end

  task automatic send_word(logic [63:0] w, logic [6:0] vb, logic fin);
    while (!calm && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, vb, w};
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic send_message(int full_words, logic [6:0] vb, logic [63:0] fin_w);
    for (int i = 0; i < full_words; i++) send_word(rand_word(), 7'($urandom), 1'b0);
    send_word(fin_w, vb, 1'b1);
  endtask

  initial begin
    int nw;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    send_message(0, 7'd0, '1);
    send_message(0, 7'd64, '1);
    send_message(0, 7'd127, '0);
    send_message(7, 7'd63, '1);
    send_message(7, 7'd64, rand_word());
    send_message(15, 7'd1, '1);
    send_message(3, 7'd37, rand_word());
    while (words_sent < 310) begin
      calm = (words_sent >= 150 && words_sent < 200);
      nw = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(9);
      send_message(nw, ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(64)),
                   rand_word());
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;
    @(posedge clk);
    while (pending_lanes != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered %0d message words and %0d digests, incl. 511/512-bit remainders.",
             words_sent, digests_seen);
    if (fail_count == 0 && pending_lanes == 0) begin
      $display("sponge_hash_512_m39_permutation_top regression: pass");
    end else begin
      $display("sponge_hash_512_m39_permutation_top regression: fail");
    end
    $finish;
  end
endmodule
